// ===== rtl/vrm_pkg.sv =====
// Shared types and constants of the voxel ray marcher.
`timescale 1ns / 1ps
package vrm_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_ULOAD,
        S_UDIV,
        S_TLOAD,
        S_TDIV,
        S_PICK,
        S_MUL,
        S_UPD,
        S_OUT
    } t_state;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [2:0] FACE_NONE = 3'd0;

    localparam int MAX_STEPS_DEF = 256;

    localparam logic [30:0] MAX_DIST_RST = 31'd16777216;
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [33:0] NUDGE_Q16    = 34'd655;

    localparam int DVD_W = 48;
    localparam int DSR_W = 32;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] UDIV_ITERS = CNT_W'(48);
    localparam logic [CNT_W-1:0] TDIV_ITERS = CNT_W'(33);
    localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(31);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(33);

endpackage

// ===== rtl/vrm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vrm_div
    import vrm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quot, n_quot;
    logic [DSR_W:0]   trial;
    logic             take;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_quot = r_quot;
        trial  = {r_rem, r_dvd[DVD_W-1]};
        take   = trial >= {1'b0, r_dsr};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_count;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = take ? DSR_W'(trial - {1'b0, r_dsr}) : trial[DSR_W-1:0];
            n_quot = {r_quot[DVD_W-2:0], take};
            n_dvd  = {r_dvd[DVD_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/voxel_ray_march.sv =====
// Top level of the voxel ray marcher (3D grid traversal, Q16.16).
//
// Input channel (i_valid/o_ready): cmd 0 starts a ray from pos along dir,
// cmd 1 answers the pending voxel query with solid. Each item gives at most
// one result on the output channel (o_valid/i_ready): a query for the next
// voxel, a hit, or a miss. An answer with no ray pending gives no result.
// Config channel (i_cfg_valid/o_cfg_ready) writes max_distance; the user must
// write it only while the block is idle, which the block does not enforce.
// One item at a time. A start normalizes dir (up to 30 shifts), squares it in
// 32 bit-serial steps, takes 32 square root steps and runs three divides of 48
// quotient bits each. An answer that steps the ray runs a 33-bit boundary
// divide for each nonzero axis and skips a zero axis, then picks the nearest
// boundary, runs a 34-step bit-serial multiply for the advance, updates the ray
// and loads the output; the divides run one at a time on the shared divider.
// A hit or a trivial miss goes straight to the output state.
// Reset clears the ray (none pending) and sets max_distance to 256.0.
// The result sits in an output register; a stalled receiver holds it there,
// the next item is still taken and its result waits until the register frees.
`timescale 1ns / 1ps
module voxel_ray_march
    import vrm_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic               i_solid,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_voxel_x,
    output logic signed [15:0] o_voxel_y,
    output logic signed [15:0] o_voxel_z,
    output logic [2:0]         o_face
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    t_state r_state, n_state;

    logic [30:0]        r_max_dist, n_max_dist;
    logic [15:0]        r_voxel  [3], n_voxel  [3];
    logic [16:0]        r_pos    [3], n_pos    [3];
    logic signed [17:0] r_udir   [3], n_udir   [3];
    logic [31:0]        r_trav, n_trav;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [2:0]         r_face, n_face;
    logic               r_active, n_active;
    logic [31:0]        r_mag    [3], n_mag    [3];
    logic               r_neg    [3], n_neg    [3];
    logic [63:0]        r_acc    [3], n_acc    [3];
    logic [63:0]        r_mcand  [3], n_mcand  [3];
    logic [33:0]        r_mplier [3], n_mplier [3];
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [63:0]        r_sq, n_sq;
    logic [63:0]        r_root, n_root;
    logic [63:0]        r_bit, n_bit;
    logic [31:0]        r_len, n_len;
    logic [1:0]         r_axis, n_axis;
    logic [1:0]         r_best, n_best;
    logic [32:0]        r_best_t, n_best_t;
    logic               r_best_ok, n_best_ok;
    logic [33:0]        r_steplen, n_steplen;
    logic [1:0]         r_kind, n_kind;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_o_kind, n_o_kind;
    logic [15:0]        r_o_vox  [3], n_o_vox  [3];
    logic [2:0]         r_o_face, n_o_face;

    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dividend, div_quot;
    logic [DSR_W-1:0] div_divisor;
    logic [CNT_W-1:0] div_count;

    logic               in_fire;
    logic signed [31:0] dir_in [3];
    logic [31:0]        pos_in [3];
    logic [31:0]        mag_in [3];
    logic [64:0]        root_try;
    logic [16:0]        bnd_dist;
    logic [16:0]        abs_u;
    logic [32:0]        t_new;
    logic [34:0]        trav_sum;
    logic signed [63:0] floor_adv;
    logic signed [63:0] nb;
    logic [17:0]        u_new;
    logic               any_nz;

    vrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_count    (div_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_fire     = i_valid && o_ready;

    assign dir_in[0] = i_dir_x;
    assign dir_in[1] = i_dir_y;
    assign dir_in[2] = i_dir_z;
    assign pos_in[0] = i_pos_x;
    assign pos_in[1] = i_pos_y;
    assign pos_in[2] = i_pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = dir_in[i][31] ? (~dir_in[i] + 32'd1) : dir_in[i];
        end
        any_nz = (mag_in[0] != '0) || (mag_in[1] != '0) || (mag_in[2] != '0);
    end

    always_comb begin
        n_state     = r_state;
        n_max_dist  = r_max_dist;
        n_voxel     = r_voxel;
        n_pos       = r_pos;
        n_udir      = r_udir;
        n_trav      = r_trav;
        n_step      = r_step;
        n_face      = r_face;
        n_active    = r_active;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_sq        = r_sq;
        n_root      = r_root;
        n_bit       = r_bit;
        n_len       = r_len;
        n_axis      = r_axis;
        n_best      = r_best;
        n_best_t    = r_best_t;
        n_best_ok   = r_best_ok;
        n_steplen   = r_steplen;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_ready;
        n_o_kind    = r_o_kind;
        n_o_vox     = r_o_vox;
        n_o_face    = r_o_face;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_count    = '0;

        root_try  = {1'b0, r_root} + {1'b0, r_bit};
        bnd_dist  = r_udir[r_axis][17] ? r_pos[r_axis] : 17'(ONE_Q16 - r_pos[r_axis]);
        abs_u     = r_udir[r_axis][17] ? 17'(-r_udir[r_axis]) : r_udir[r_axis][16:0];
        t_new     = div_quot[32:0];
        trav_sum  = {3'b0, r_trav} + {1'b0, r_steplen};
        floor_adv = '0;
        nb        = '0;
        u_new     = r_neg[r_axis] ? 18'(-div_quot[17:0]) : div_quot[17:0];

        if (i_cfg_valid) begin
            n_max_dist = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (!i_cmd) begin
                        if (!any_nz) begin
                            n_active = 1'b0;
                            n_kind   = KIND_MISS;
                            n_state  = S_OUT;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                n_mag[i]   = mag_in[i];
                                n_neg[i]   = dir_in[i][31];
                                n_voxel[i] = pos_in[i][31:16];
                                n_pos[i]   = {1'b0, pos_in[i][15:0]};
                            end
                            n_trav   = '0;
                            n_step   = '0;
                            n_face   = FACE_NONE;
                            n_active = 1'b1;
                            n_state  = S_NORM;
                        end
                    end else if (r_active) begin
                        if (i_solid) begin
                            n_active = 1'b0;
                            n_kind   = KIND_HIT;
                            n_state  = S_OUT;
                        end else begin
                            n_axis    = '0;
                            n_best_ok = 1'b0;
                            n_state   = S_TLOAD;
                        end
                    end
                end
            end
            S_NORM: begin
                if ((r_mag[0][31:30] | r_mag[1][31:30] | r_mag[2][31:30]) == 2'b00) begin
                    for (int i = 0; i < 3; i++) begin
                        n_mag[i] = {r_mag[i][30:0], 1'b0};
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n_acc[i]    = '0;
                        n_mcand[i]  = {32'b0, r_mag[i]};
                        n_mplier[i] = {2'b0, r_mag[i]};
                    end
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_mplier[i][0]) begin
                        n_acc[i] = r_acc[i] + r_mcand[i];
                    end
                    n_mcand[i]  = {r_mcand[i][62:0], 1'b0};
                    n_mplier[i] = {1'b0, r_mplier[i][33:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_sq    = n_acc[0] + n_acc[1] + n_acc[2];
                    n_root  = '0;
                    n_bit   = 64'h4000_0000_0000_0000;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if ({1'b0, r_sq} >= root_try) begin
                    n_sq   = r_sq - root_try[63:0];
                    n_root = {1'b0, r_root[63:1]} + r_bit;
                end else begin
                    n_root = {1'b0, r_root[63:1]};
                end
                n_bit = {2'b0, r_bit[63:2]};
                if (r_bit[0]) begin
                    n_len   = n_root[31:0];
                    n_axis  = '0;
                    n_state = S_ULOAD;
                end
            end
            S_ULOAD: begin
                div_start    = 1'b1;
                div_dividend = {r_mag[r_axis], 16'h0} + {17'h0, r_len[31:1]};
                div_divisor  = r_len;
                div_count    = UDIV_ITERS;
                n_state      = S_UDIV;
            end
            S_UDIV: begin
                if (div_done) begin
                    n_udir[r_axis] = u_new;
                    if (r_axis == 2'd2) begin
                        n_kind  = KIND_QUERY;
                        n_state = S_OUT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_ULOAD;
                    end
                end
            end
            S_TLOAD: begin
                if (r_udir[r_axis] == '0) begin
                    if (r_axis == 2'd2) begin
                        n_state = S_PICK;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {bnd_dist, 31'h0};
                    div_divisor  = {15'h0, abs_u};
                    div_count    = TDIV_ITERS;
                    n_state      = S_TDIV;
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    if (!r_best_ok || (t_new < r_best_t)) begin
                        n_best    = r_axis;
                        n_best_t  = t_new;
                        n_best_ok = 1'b1;
                    end
                    if (r_axis == 2'd2) begin
                        n_state = S_PICK;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_TLOAD;
                    end
                end
            end
            S_PICK: begin
                if (!r_best_ok) begin
                    n_active = 1'b0;
                    n_kind   = KIND_MISS;
                    n_state  = S_OUT;
                end else begin
                    n_steplen = {1'b0, r_best_t} + NUDGE_Q16;
                    for (int i = 0; i < 3; i++) begin
                        n_acc[i]    = '0;
                        n_mcand[i]  = 64'(r_udir[i]);
                        n_mplier[i] = n_steplen;
                    end
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_mplier[i][0]) begin
                        n_acc[i] = r_acc[i] + r_mcand[i];
                    end
                    n_mcand[i]  = {r_mcand[i][62:0], 1'b0};
                    n_mplier[i] = {1'b0, r_mplier[i][33:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_trav  = (trav_sum[34:32] != 3'b0) ? 32'hFFFF_FFFF : trav_sum[31:0];
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) == r_best) begin
                        if (!r_udir[i][17]) begin
                            n_voxel[i] = r_voxel[i] + 16'd1;
                            n_pos[i]   = '0;
                        end else begin
                            n_voxel[i] = r_voxel[i] - 16'd1;
                            n_pos[i]   = ONE_Q16;
                        end
                    end else begin
                        floor_adv = $signed(r_acc[i]) >>> 16;
                        nb        = $signed({47'b0, r_pos[i]}) + floor_adv;
                        if (nb < 0) begin
                            n_pos[i] = '0;
                        end else if (nb > $signed({47'b0, ONE_Q16})) begin
                            n_pos[i] = ONE_Q16;
                        end else begin
                            n_pos[i] = nb[16:0];
                        end
                    end
                end
                n_face = {r_best, 1'b0} + (r_udir[r_best][17] ? 3'd2 : 3'd1);
                n_step = r_step + 1'b1;
                if ((r_trav > {1'b0, r_max_dist}) || (n_step >= STEP_W'(MAX_STEPS))) begin
                    n_active = 1'b0;
                    n_kind   = KIND_MISS;
                end else begin
                    n_kind = KIND_QUERY;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = r_kind;
                    for (int i = 0; i < 3; i++) begin
                        n_o_vox[i] = (r_kind == KIND_MISS) ? 16'h0 : r_voxel[i];
                    end
                    n_o_face = (r_kind == KIND_MISS) ? FACE_NONE : r_face;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_dist  <= MAX_DIST_RST;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_trav      <= '0;
            r_step      <= '0;
            r_face      <= FACE_NONE;
            for (int i = 0; i < 3; i++) begin
                r_voxel[i] <= '0;
                r_pos[i]   <= '0;
                r_udir[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_max_dist  <= n_max_dist;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_trav      <= n_trav;
            r_step      <= n_step;
            r_face      <= n_face;
            r_voxel     <= n_voxel;
            r_pos       <= n_pos;
            r_udir      <= n_udir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_acc     <= n_acc;
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_cnt     <= n_cnt;
        r_sq      <= n_sq;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_len     <= n_len;
        r_axis    <= n_axis;
        r_best    <= n_best;
        r_best_t  <= n_best_t;
        r_best_ok <= n_best_ok;
        r_steplen <= n_steplen;
        r_kind    <= n_kind;
        r_o_kind  <= n_o_kind;
        r_o_vox   <= n_o_vox;
        r_o_face  <= n_o_face;
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_o_kind;
    assign o_voxel_x = r_o_vox[0];
    assign o_voxel_y = r_o_vox[1];
    assign o_voxel_z = r_o_vox[2];
    assign o_face    = r_o_face;

endmodule
